/* hdl/rcl_pkg.sv */
// Shared types and constants for the per-client rate and connection limiter.
// Used by rcl_table, rcl_update and the top level; depends on nothing else.
package rcl_pkg;

    localparam int CLIENT_SLOTS_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECTION_CAP = 2'd2;

    localparam logic [7:0]  REQUEST_LIMIT_RST  = 8'd10;
    localparam logic [15:0] WINDOW_LENGTH_RST  = 16'd60;
    localparam logic [2:0]  CONNECTION_CAP_RST = 3'd5;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_OK   = 2'd0,
        VERDICT_RATE = 2'd1,
        VERDICT_CONN = 2'd2
    } t_verdict;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    typedef struct packed {
        logic        seen;
        logic [7:0]  count;
        logic [31:0] start;
        logic [2:0]  conn;
    } t_entry;

    typedef struct packed {
        logic [7:0]  request_limit;
        logic [15:0] window_length;
        logic [2:0]  connection_cap;
    } t_cfg;

endpackage

/* hdl/rcl_table.sv */
// Client table: one synchronous memory with one write and one registered read port.
// Depends on rcl_pkg for the entry type.
module rcl_table
    import rcl_pkg::*;
#(
    parameter int DEPTH  = CLIENT_SLOTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_entry            o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rcl_update.sv */
// Entry update: window restart, request counting, verdict and connection bookkeeping.
// Depends on rcl_pkg for the entry, configuration and verdict types.
module rcl_update
    import rcl_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic        i_command,
    input  logic [31:0] i_now,
    input  t_entry      i_entry,
    output t_entry      o_entry,
    output t_verdict    o_verdict
);

    logic [31:0] age;
    logic        restart;
    logic [7:0]  count_base;
    logic [7:0]  count_next;

    always_comb begin
        // The age wraps modulo 2^32, as the time stamps do.
        age        = i_now - i_entry.start;
        restart    = i_entry.seen && (age > {16'b0, i_cfg.window_length});
        count_base = restart ? 8'd0 : i_entry.count;
        count_next = (count_base == COUNT_MAX) ? COUNT_MAX : count_base + 8'd1;

        o_entry   = i_entry;
        o_verdict = VERDICT_OK;
        if (i_command == CMD_REQUEST) begin
            o_entry.seen  = 1'b1;
            o_entry.count = count_next;
            o_entry.start = restart ? i_now : i_entry.start;
            if (count_next > i_cfg.request_limit) begin
                o_verdict = VERDICT_RATE;
            end else if (i_entry.conn >= i_cfg.connection_cap) begin
                o_verdict = VERDICT_CONN;
            end else begin
                o_entry.conn = i_entry.conn + 3'd1;
            end
        end else if (i_entry.conn != 3'd0) begin
            o_entry.conn = i_entry.conn - 3'd1;
        end
    end

endmodule

/* hdl/per_client_rate_and_connection_limiter.sv */
// Per-client fixed-window rate limiter with a cap on open connections. After reset the
// table is swept clear, one slot per cycle, and no command is taken until the sweep has
// passed every slot; configuration writes are taken throughout. Then one command is
// taken every cycle unless the output stalls: the slot is read from the table memory as
// the command is taken, then updated and written back as the command leaves the first
// stage, on the same edge that loads the output register. A write-back is forwarded to a
// read of the same slot that overlaps it; commands to one client may follow back to back.
// Depends on rcl_pkg, rcl_table and rcl_update.
module per_client_rate_and_connection_limiter
    import rcl_pkg::*;
#(
    parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  logic [7:0]            i_client_slot,
    input  logic [31:0]           i_now_seconds,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_verdict,
    output logic [7:0]            o_request_count,
    output logic [2:0]            o_open_connections
);

    localparam int SLOT_W = $clog2(CLIENT_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CLIENT_SLOTS - 1);

    t_state r_state;
    t_state n_state;
    logic   clearing;

    logic [SLOT_W-1:0] r_clr_addr;
    t_cfg              r_cfg;

    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic              r_s1_inrange;
    logic [SLOT_W-1:0] r_s1_addr;
    logic [31:0]       r_s1_now;

    logic              r_fwd_valid;
    logic [SLOT_W-1:0] r_fwd_addr;
    t_entry            r_fwd_entry;

    logic        r_out_valid;
    t_verdict    r_out_verdict;
    logic [7:0]  r_out_count;
    logic [2:0]  r_out_conn;

    logic              in_accept;
    logic              s1_go;
    logic [16:0]       slot_ext;
    logic [SLOT_W-1:0] in_addr;
    logic              in_range;
    t_entry            rd_entry;
    t_entry            cur_entry;
    t_entry            upd_entry;
    t_verdict          upd_verdict;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    t_entry            mem_wdata;

    // Sequencer: clearing sweep after reset, then normal operation.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == SLOT_LAST) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.request_limit  <= REQUEST_LIMIT_RST;
            r_cfg.window_length  <= WINDOW_LENGTH_RST;
            r_cfg.connection_cap <= CONNECTION_CAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_REQUEST_LIMIT:  r_cfg.request_limit  <= i_cfg_wdata[7:0];
                REG_WINDOW_LENGTH:  r_cfg.window_length  <= i_cfg_wdata[15:0];
                REG_CONNECTION_CAP: r_cfg.connection_cap <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Handshake and address decode.
    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !clearing && (!r_s1_valid || s1_go);
    assign in_accept  = i_in_valid && o_in_ready;
    assign slot_ext   = {9'b0, i_client_slot};
    assign in_addr    = slot_ext[SLOT_W-1:0];
    assign in_range   = ({24'b0, i_client_slot} < 32'(CLIENT_SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd     <= i_command;
            r_s1_inrange <= in_range;
            r_s1_addr    <= in_addr;
            r_s1_now     <= i_now_seconds;
        end
    end

    assign mem_we    = clearing || (s1_go && r_s1_inrange);
    assign mem_waddr = clearing ? r_clr_addr : r_s1_addr;
    assign mem_wdata = clearing ? t_entry'('0) : upd_entry;

    rcl_table #(
        .DEPTH  (CLIENT_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_accept),
        .i_raddr (in_addr),
        .o_rdata (rd_entry)
    );

    // The last write-back is kept, since the read of the following command
    // happens on the same edge and sees the old contents.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (clearing) begin
            r_fwd_valid <= 1'b0;
        end else if (mem_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fwd_addr  <= mem_waddr;
            r_fwd_entry <= mem_wdata;
        end
    end

    assign cur_entry = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_entry : rd_entry;

    rcl_update u_update (
        .i_cfg     (r_cfg),
        .i_command (r_s1_cmd),
        .i_now     (r_s1_now),
        .i_entry   (cur_entry),
        .o_entry   (upd_entry),
        .o_verdict (upd_verdict)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            if (r_s1_inrange) begin
                r_out_verdict <= upd_verdict;
                r_out_count   <= upd_entry.count;
                r_out_conn    <= upd_entry.conn;
            end else begin
                r_out_verdict <= (r_s1_cmd == CMD_REQUEST) ? VERDICT_RATE : VERDICT_OK;
                r_out_count   <= 8'd0;
                r_out_conn    <= 3'd0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_verdict          = r_out_verdict;
    assign o_request_count    = r_out_count;
    assign o_open_connections = r_out_conn;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_in_ready
    ) else $error("command taken during the clearing sweep");

    a_sweep_ends: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (clearing && (r_clr_addr == SLOT_LAST)) |=> (r_state == ST_RUN)
    ) else $error("clearing sweep did not finish after the last slot");

    a_release_ok: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_s1_cmd == CMD_RELEASE)) |=> (o_verdict == VERDICT_OK)
    ) else $error("release gave a refusal verdict");

    a_admit_within_cap: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_inrange && (r_s1_cmd == CMD_REQUEST) && (upd_verdict == VERDICT_OK))
        |-> (upd_entry.conn <= r_cfg.connection_cap)
    ) else $error("admitted request exceeded the connection cap");

    a_out_of_range_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && !r_s1_inrange) |=> ((o_request_count == 8'd0) && (o_open_connections == 3'd0))
    ) else $error("out-of-range slot reported nonzero counts");
`endif

endmodule
